// ----- sv/crs_pkg.sv -----
// Shared constants and types for the closed Catmull-Rom sampler.
package crs_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int MARGIN     = 8;

  // Divider operand widths: dividend is the pre-scaled sample, divisor is steps cubed.
  localparam int DIV_W = 40;
  localparam int DEN_W = 18;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_EMIT   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_STEPS  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_H1,
    ST_H2,
    ST_H3,
    ST_SCALE,
    ST_DIV_GO,
    ST_DIV_WAIT
  } st_e;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

// ----- sv/closed_catmull_rom_sampler_core.sv -----
// Top level: control point ring memory, sample sequencer and pixel mapping.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------------
//  command  | start / busy                 | op_i, point_x_i, point_y_i, segment_i
//  result   | result_valid_o (strobe)      | pixel_x_o, pixel_y_o, path_start_o,
//           |                              | last_sample_o
//  config   | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
// Clear, append and rejected emit commands never raise busy.
// An emit fetches four points from the ring memory, then computes steps+1 samples
// (a zero step setting counts as one), each as two coordinates that pass through
// the Horner steps, the scale step and the serial divider in turn.
// Reset clears the point count and loads the default canvas and step registers.
// Each result is shown for one cycle; the receiver cannot stall.
module closed_catmull_rom_sampler_core
  import crs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op_i,
  input  logic [15:0]        point_x_i,
  input  logic [15:0]        point_y_i,
  input  logic [5:0]         segment_i,
  output logic               result_valid_o,
  output logic signed [15:0] pixel_x_o,
  output logic signed [15:0] pixel_y_o,
  output logic               path_start_o,
  output logic               last_sample_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [11:0]        cfg_data_i
);

  localparam logic signed [12:0] SPAN_OFF = 13'(2 * MARGIN);
  localparam logic signed [41:0] OFS_Q4   = 42'(16 * MARGIN);

  st_e st_q, st_d;

  logic [11:0]       width_q, height_q;
  logic [5:0]        steps_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [31:0]       mem_q [MAX_POINTS];
  logic [31:0]       rd_q;
  logic [ADDR_W-1:0] rd_addr;
  logic [31:0]       e_q [4];
  logic [2:0]        fc_q;
  logic [5:0]        seg_q, s_q, smax_q;
  logic [11:0]       s2_q;
  logic [DEN_W-1:0]  s3_q;
  logic              sel_y_q;
  logic signed [39:0] h_q, h_d;
  logic signed [55:0] p_q;
  logic signed [55:0] m_full;
  logic signed [15:0] px_q, py_q, sat;
  logic              valid_q, pstart_q, last_q;

  logic              accept, emit_ok;
  logic [5:0]        steps_eff;
  logic [CNT_W-1:0]  kk, i0, i2, i3, kp1, kp2;
  div_ctl_t          div_ctl;
  logic signed [DIV_W:0] quo;
  logic signed [41:0] q_ofs;

  logic [15:0]        ua, ub, uc, ud;
  logic signed [20:0] a21, b21, c21, d21, k3, k2, k1, k0;
  logic signed [7:0]  s8, smax8;
  logic signed [12:0] s2s, span;
  logic signed [DEN_W:0] s3s;

  assign accept    = start && !busy;
  assign emit_ok   = (op_i == OP_EMIT) && (cnt_q >= CNT_W'(2)) && (CNT_W'(segment_i) < cnt_q);
  assign steps_eff = (steps_q == '0) ? 6'd1 : steps_q;
  assign cfg_ready_o = 1'b1;

  // Ring neighbors of the segment, wrapped by the point count.
  assign kk  = CNT_W'(seg_q);
  assign kp1 = kk + CNT_W'(1);
  assign kp2 = kk + CNT_W'(2);
  assign i0  = (kk == '0) ? cnt_q - CNT_W'(1) : kk - CNT_W'(1);
  assign i2  = (kp1 >= cnt_q) ? kp1 - cnt_q : kp1;
  assign i3  = (kp2 >= cnt_q) ? kp2 - cnt_q : kp2;

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:     if (accept && emit_ok) st_d = ST_FETCH;
      ST_FETCH:    if (fc_q == 3'd4) st_d = ST_H1;
      ST_H1:       st_d = ST_H2;
      ST_H2:       st_d = ST_H3;
      ST_H3:       st_d = ST_SCALE;
      ST_SCALE:    st_d = ST_DIV_GO;
      ST_DIV_GO:   st_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_ctl.done) begin
          st_d = (sel_y_q && s_q == smax_q) ? ST_IDLE : ST_H1;
        end
      end
      default:     st_d = ST_IDLE;
    endcase
  end

  assign div_ctl.start = (st_q == ST_DIV_GO);

  // Control outputs.
  always_comb begin
    busy          = (st_q != ST_IDLE);
    unique case (fc_q[1:0])
      2'd0:    rd_addr = i0[ADDR_W-1:0];
      2'd1:    rd_addr = kk[ADDR_W-1:0];
      2'd2:    rd_addr = i2[ADDR_W-1:0];
      default: rd_addr = i3[ADDR_W-1:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      cnt_q    <= '0;
      width_q  <= 12'd320;
      height_q <= 12'd240;
      steps_q  <= 6'd20;
      valid_q  <= 1'b0;
      pstart_q <= 1'b0;
      last_q   <= 1'b0;
      fc_q     <= '0;
      s_q      <= '0;
      sel_y_q  <= 1'b0;
    end else begin
      st_q     <= st_d;
      valid_q  <= 1'b0;
      pstart_q <= 1'b0;
      last_q   <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_WIDTH:  width_q  <= cfg_data_i;
          CFG_HEIGHT: height_q <= cfg_data_i;
          CFG_STEPS:  steps_q  <= cfg_data_i[5:0];
          default:    ;
        endcase
      end
      if (accept) begin
        unique case (op_e'(op_i))
          OP_CLEAR:  cnt_q <= '0;
          OP_APPEND: if (cnt_q < CNT_W'(MAX_POINTS)) cnt_q <= cnt_q + CNT_W'(1);
          default:   ;
        endcase
        fc_q    <= '0;
        s_q     <= '0;
        sel_y_q <= 1'b0;
      end
      if (st_q == ST_FETCH) fc_q <= fc_q + 3'd1;
      if (st_q == ST_DIV_WAIT && div_ctl.done) begin
        sel_y_q <= !sel_y_q;
        if (sel_y_q) begin
          valid_q  <= 1'b1;
          pstart_q <= (seg_q == '0) && (s_q == '0);
          last_q   <= (s_q == smax_q);
          s_q      <= s_q + 6'd1;
        end
      end
    end
  end

  // Point ring memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (accept && op_i == OP_APPEND && cnt_q < CNT_W'(MAX_POINTS)) begin
      mem_q[cnt_q[ADDR_W-1:0]] <= {point_y_i, point_x_i};
    end
    rd_q <= mem_q[rd_addr];
  end

  // Per-coordinate operands.
  assign ua = sel_y_q ? e_q[0][31:16] : e_q[0][15:0];
  assign ub = sel_y_q ? e_q[1][31:16] : e_q[1][15:0];
  assign uc = sel_y_q ? e_q[2][31:16] : e_q[2][15:0];
  assign ud = sel_y_q ? e_q[3][31:16] : e_q[3][15:0];
  assign a21 = $signed({5'b0, ua});
  assign b21 = $signed({5'b0, ub});
  assign c21 = $signed({5'b0, uc});
  assign d21 = $signed({5'b0, ud});
  assign k3  = d21 - a21 + 21'sd3 * (b21 - c21);
  assign k2  = 21'sd2 * a21 - 21'sd5 * b21 + 21'sd4 * c21 - d21;
  assign k1  = c21 - a21;
  assign k0  = 21'sd2 * b21;
  assign s8    = $signed({2'b0, s_q});
  assign smax8 = $signed({2'b0, smax_q});
  assign s2s   = $signed({1'b0, s2_q});
  assign s3s   = $signed({1'b0, s3_q});
  assign span  = sel_y_q ? $signed({1'b0, height_q}) - SPAN_OFF
                         : $signed({1'b0, width_q}) - SPAN_OFF;

  // Horner evaluation of the cubic numerator, two products per step.
  always_comb begin
    unique case (st_q)
      ST_H1:   h_d = k3 * s8 + k2 * smax8;
      ST_H2:   h_d = h_q * s8 + k1 * s2s;
      default: h_d = h_q * s8 + k0 * s3s;
    endcase
  end

  // Rounding half of the denominator, pre-shifted by the fixed power of two.
  assign m_full = p_q + $signed({20'b0, s3_q, 12'b0}) + 56'sd0;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      seg_q  <= segment_i;
      smax_q <= steps_eff;
      s2_q   <= 12'(steps_eff * steps_eff);
    end
    if (st_q == ST_FETCH) begin
      s3_q <= DEN_W'(s2_q * smax_q);
      if (fc_q != 3'd0) e_q[2'(fc_q - 3'd1)] <= rd_q;
    end
    if (st_q == ST_H1 || st_q == ST_H2 || st_q == ST_H3) h_q <= h_d;
    if (st_q == ST_SCALE) p_q <= 56'(h_q * span);
    if (st_q == ST_DIV_WAIT && div_ctl.done) begin
      if (sel_y_q) py_q <= sat;
      else px_q <= sat;
    end
  end

  crs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_ctl.start),
    .dividend_i (m_full[DIV_W+12:13]),
    .divisor_i  (s3_q),
    .done_o     (div_ctl.done),
    .quotient_o (quo)
  );

  assign q_ofs = 42'(quo) + OFS_Q4;
  always_comb begin
    if (q_ofs > 42'sd32767) sat = 16'sh7fff;
    else if (q_ofs < -42'sd32768) sat = -16'sh8000;
    else sat = q_ofs[15:0];
  end

  assign result_valid_o = valid_q;
  assign pixel_x_o      = px_q;
  assign pixel_y_o      = py_q;
  assign path_start_o   = pstart_q;
  assign last_sample_o  = last_q;

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_sample_o) |-> !busy)
    else $error("busy still high after the last sample of a run");

  a_strobe_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (path_start_o || last_sample_o) |-> result_valid_o)
    else $error("result flag without a result strobe");

  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == OP_APPEND && cnt_q < CNT_W'(MAX_POINTS))
      |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("append did not advance the point count");

  a_div_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.done |-> (st_q == ST_DIV_WAIT))
    else $error("divider finished outside the wait step");

endmodule

// ----- sv/crs_div.sv -----
// Iterative floor divider: signed dividend by positive divisor, one bit per cycle.
module crs_div
  import crs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DIV_W-1:0]  dividend_i,
  input  logic        [DEN_W-1:0]  divisor_i,
  output logic                     done_o,
  output logic signed [DIV_W:0]    quotient_o
);

  localparam int ITER_W = $clog2(DIV_W + 1);

  logic              run_q;
  logic              done_q;
  logic [ITER_W-1:0] iter_q;
  logic              neg_q;
  logic [DIV_W-1:0]  quo_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W:0]    trial;
  logic              fits;
  logic [DIV_W:0]    mag_up;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        iter_q <= ITER_W'(DIV_W);
      end else if (run_q) begin
        iter_q <= iter_q - 1'b1;
        if (iter_q == ITER_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DIV_W-1];
      quo_q <= dividend_i[DIV_W-1] ? DIV_W'(-dividend_i) : DIV_W'(dividend_i);
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  // Negative dividends round toward minus infinity.
  assign mag_up     = {1'b0, quo_q} + (DIV_W+1)'(rem_q != '0);
  assign quotient_o = neg_q ? -$signed(mag_up) : $signed({1'b0, quo_q});
  assign done_o     = done_q;

endmodule
